// File: src/pbr_pkg.sv
// Shared types and constants for the pulse beat rate detector.
// Field widths, register map, divider request/response and sequencer states.
// No dependencies; compile first.
package pbr_pkg;

	localparam int HISTORY_DEPTH_DEF = 10;

	localparam int SAMPLE_W = 10;
	localparam int TICK_W   = 16;
	localparam int IVL_W    = 8;
	localparam int BPM_W    = 8;
	localparam int NUM_W    = 24;
	localparam int DIVS_W   = 8;
	localparam int STEP_W   = $clog2(NUM_W + 1);

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	localparam int MIN_BEATS = 3;

	localparam logic [SAMPLE_W-1:0] TRACK_RST = 10'd512;

	localparam logic [IVL_W-1:0] MIN_INTERVAL_RST   = 8'd20;
	localparam logic [IVL_W-1:0] MAX_INTERVAL_RST   = 8'd200;
	localparam logic [NUM_W-1:0] RATE_NUMERATOR_RST = 24'd1171875;
	localparam logic [BPM_W-1:0] BPM_FLOOR_RST      = 8'd50;
	localparam logic [BPM_W-1:0] BPM_CEILING_RST    = 8'd180;
	localparam logic [IVL_W-1:0] WINDOW_SAMPLES_RST = 8'd100;

	typedef enum logic [2:0] {
		REG_MIN_INTERVAL   = 3'd0,
		REG_MAX_INTERVAL   = 3'd1,
		REG_RATE_NUMERATOR = 3'd2,
		REG_BPM_FLOOR      = 3'd3,
		REG_BPM_CEILING    = 3'd4,
		REG_WINDOW_SAMPLES = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [IVL_W-1:0] min_interval;
		logic [IVL_W-1:0] max_interval;
		logic [NUM_W-1:0] rate_numerator;
		logic [BPM_W-1:0] bpm_floor;
		logic [BPM_W-1:0] bpm_ceiling;
		logic [IVL_W-1:0] window_samples;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  dividend;
		logic [DIVS_W-1:0] divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_THR,
		ST_BEAT,
		ST_SUM,
		ST_MEAN,
		ST_MEAN_WAIT,
		ST_RATE_WAIT,
		ST_EMIT
	} state_t;

endpackage

// File: src/pbr_in_if.sv
// Input word channel: valid/ready handshake carrying sample and timestamp.
// Depends on pbr_pkg for field widths.
interface pbr_in_if;
	import pbr_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic [TICK_W-1:0]   timestamp;

	modport source (output valid, output sample, output timestamp, input ready);
	modport sink (input valid, input sample, input timestamp, output ready);
endinterface

// File: src/pbr_out_if.sv
// Result word channel: valid/ready handshake carrying bpm, beat flags and threshold.
// Depends on pbr_pkg for field widths.
interface pbr_out_if;
	import pbr_pkg::*;

	logic                valid;
	logic                ready;
	logic [BPM_W-1:0]    bpm;
	logic                beat_detected;
	logic                bpm_updated;
	logic [SAMPLE_W-1:0] threshold_level;

	modport source (output valid, output bpm, output beat_detected, output bpm_updated,
		output threshold_level, input ready);
	modport sink (input valid, input bpm, input beat_detected, input bpm_updated,
		input threshold_level, output ready);
endinterface

// File: src/pulse_beat_rate_detector.sv
// Pulse beat rate detector, top level: sequencer around one shared divider.
// A word with no bpm update passes ST_THR, ST_BEAT and ST_EMIT before ready returns in ST_IDLE.
// A bpm update adds the ring sum, a 12-step mean and a 24-step rate division before ST_EMIT.
// One word at a time; the result register frees the input while a result waits to be taken.
// arst_n clears all tracking state, the interval count and bpm; ring entries are not cleared.
module pulse_beat_rate_detector #(
	parameter int HISTORY_DEPTH = pbr_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	pbr_in_if.sink                     pulse,
	pbr_out_if.source                  report,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pbr_pkg::APB_AW-1:0] paddr,
	input  logic [pbr_pkg::APB_DW-1:0] pwdata,
	output logic [pbr_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import pbr_pkg::*;

	localparam int SLOT_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = IVL_W + $clog2(HISTORY_DEPTH);

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;
	state_t   state_q;
	state_t   state_d;

	logic [SAMPLE_W-1:0] s_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] prior_q;
	logic [SAMPLE_W-1:0] thr_q;
	logic [SAMPLE_W-1:0] thr_d;
	logic [TICK_W-1:0]   ts_q;
	logic [TICK_W-1:0]   last_q;
	logic [TICK_W-1:0]   gap_q;
	logic [IVL_W-1:0]    ring_q [HISTORY_DEPTH];
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_inc;
	logic [CNT_W-1:0]    idx_q;
	logic [IVL_W-1:0]    wc_q;
	logic [IVL_W:0]      wc_next;
	logic [BPM_W-1:0]    bpm_q;
	logic                beat_q;
	logic                upd_q;
	logic [SUM_W-1:0]    total_q;

	logic                out_valid_q;
	logic [BPM_W-1:0]    out_bpm_q;
	logic                out_beat_q;
	logic                out_upd_q;
	logic [SAMPLE_W-1:0] out_thr_q;

	logic              take;
	logic              crossing;
	logic              beat_ok;
	logic              win_hit;
	logic              sum_last;
	logic              out_free;
	logic [IVL_W-1:0]  mean;
	logic [NUM_W-1:0]  raised;
	logic [BPM_W-1:0]  clamped;

	pbr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pbr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign pulse.ready = (state_q == ST_IDLE);
	assign take        = pulse.valid && pulse.ready;

	assign crossing = (s_q > thr_q) && (prior_q <= thr_q);
	assign beat_ok  = crossing && (gap_q > TICK_W'(cfg.min_interval))
		&& (gap_q < TICK_W'(cfg.max_interval));
	assign cnt_inc  = (cnt_q < CNT_W'(HISTORY_DEPTH)) ? cnt_q + CNT_W'(1) : cnt_q;
	assign wc_next  = {1'b0, wc_q} + (IVL_W + 1)'(1);
	assign win_hit  = wc_next >= {1'b0, cfg.window_samples};
	assign sum_last = (idx_q + CNT_W'(1)) == cnt_q;
	assign out_free = !out_valid_q || report.ready;

	assign mean    = div_rsp.quotient[IVL_W-1:0];
	assign raised  = (div_rsp.quotient < NUM_W'(cfg.bpm_floor)) ? NUM_W'(cfg.bpm_floor)
		: div_rsp.quotient;
	assign clamped = (raised > NUM_W'(cfg.bpm_ceiling)) ? cfg.bpm_ceiling : raised[BPM_W-1:0];

	always_comb begin
		if (max_q >= min_q) begin
			thr_d = min_q + ((max_q - min_q) >> 1);
		end else begin
			thr_d = max_q + ((min_q - max_q) >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (take) state_d = ST_THR;
			end
			ST_THR: begin
				state_d = ST_BEAT;
			end
			ST_BEAT: begin
				if (beat_ok && (cnt_inc >= CNT_W'(MIN_BEATS))) state_d = ST_SUM;
				else state_d = ST_EMIT;
			end
			ST_SUM: begin
				if (sum_last) state_d = ST_MEAN;
			end
			ST_MEAN: begin
				div_req.start    = 1'b1;
				div_req.dividend = NUM_W'(total_q) << (NUM_W - SUM_W);
				div_req.divisor  = DIVS_W'(cnt_q);
				div_req.steps    = STEP_W'(SUM_W);
				state_d          = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (div_rsp.done) begin
					if (mean == '0) begin
						state_d = ST_EMIT;
					end else begin
						div_req.start    = 1'b1;
						div_req.dividend = cfg.rate_numerator;
						div_req.divisor  = mean;
						div_req.steps    = STEP_W'(NUM_W);
						state_d          = ST_RATE_WAIT;
					end
				end
			end
			ST_RATE_WAIT: begin
				if (div_rsp.done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= TRACK_RST;
			min_q   <= TRACK_RST;
			prior_q <= '0;
			last_q  <= '0;
			slot_q  <= '0;
			cnt_q   <= '0;
			wc_q    <= '0;
			bpm_q   <= '0;
			beat_q  <= 1'b0;
			upd_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						beat_q <= 1'b0;
						upd_q  <= 1'b0;
						if (pulse.sample > max_q) max_q <= pulse.sample;
						if (pulse.sample < min_q) min_q <= pulse.sample;
					end
				end
				ST_BEAT: begin
					prior_q <= s_q;
					if (beat_ok) begin
						slot_q <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
							: slot_q + SLOT_W'(1);
						cnt_q  <= cnt_inc;
						last_q <= ts_q;
						beat_q <= 1'b1;
					end
					if (win_hit) begin
						wc_q  <= '0;
						max_q <= s_q;
						min_q <= s_q;
					end else begin
						wc_q <= wc_next[IVL_W-1:0];
					end
				end
				ST_MEAN_WAIT: begin
					if (div_rsp.done && (mean == '0)) begin
						bpm_q <= cfg.bpm_ceiling;
						upd_q <= 1'b1;
					end
				end
				ST_RATE_WAIT: begin
					if (div_rsp.done) begin
						bpm_q <= clamped;
						upd_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					s_q  <= pulse.sample;
					ts_q <= pulse.timestamp;
				end
			end
			ST_THR: begin
				thr_q <= thr_d;
				gap_q <= ts_q - last_q;
			end
			ST_BEAT: begin
				if (beat_ok) ring_q[slot_q] <= gap_q[IVL_W-1:0];
				total_q <= '0;
				idx_q   <= '0;
			end
			ST_SUM: begin
				total_q <= total_q + SUM_W'(ring_q[idx_q[SLOT_W-1:0]]);
				idx_q   <= idx_q + CNT_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			out_bpm_q  <= bpm_q;
			out_beat_q <= beat_q;
			out_upd_q  <= upd_q;
			out_thr_q  <= thr_q;
		end
	end

	assign report.valid           = out_valid_q;
	assign report.bpm             = out_bpm_q;
	assign report.beat_detected   = out_beat_q;
	assign report.bpm_updated     = out_upd_q;
	assign report.threshold_level = out_thr_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(HISTORY_DEPTH))
		else $error("beat count above history depth");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, slot_q} < (SLOT_W + 1)'(HISTORY_DEPTH))
		else $error("ring slot out of range");

	a_upd_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid && report.bpm_updated |-> report.beat_detected)
		else $error("bpm updated without an accepted beat");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_MEAN_WAIT || state_q == ST_RATE_WAIT))
		else $error("divider finished outside a wait state");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !pulse.ready)
		else $error("ready again right after accepting a word");
`endif

endmodule

// File: src/pbr_regs.sv
// APB-style configuration register file for the pulse beat rate detector.
// Depends on pbr_pkg for the register map and the cfg_t bundle.
module pbr_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pbr_pkg::APB_AW-1:0]  paddr,
	input  logic [pbr_pkg::APB_DW-1:0]  pwdata,
	output logic [pbr_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output pbr_pkg::cfg_t               cfg
);
	import pbr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_interval   <= MIN_INTERVAL_RST;
			cfg_q.max_interval   <= MAX_INTERVAL_RST;
			cfg_q.rate_numerator <= RATE_NUMERATOR_RST;
			cfg_q.bpm_floor      <= BPM_FLOOR_RST;
			cfg_q.bpm_ceiling    <= BPM_CEILING_RST;
			cfg_q.window_samples <= WINDOW_SAMPLES_RST;
		end else if (wr_en) begin
			case (idx)
				REG_MIN_INTERVAL:   cfg_q.min_interval   <= pwdata[IVL_W-1:0];
				REG_MAX_INTERVAL:   cfg_q.max_interval   <= pwdata[IVL_W-1:0];
				REG_RATE_NUMERATOR: cfg_q.rate_numerator <= pwdata[NUM_W-1:0];
				REG_BPM_FLOOR:      cfg_q.bpm_floor      <= pwdata[BPM_W-1:0];
				REG_BPM_CEILING:    cfg_q.bpm_ceiling    <= pwdata[BPM_W-1:0];
				REG_WINDOW_SAMPLES: cfg_q.window_samples <= pwdata[IVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_MIN_INTERVAL:   prdata = APB_DW'(cfg_q.min_interval);
			REG_MAX_INTERVAL:   prdata = APB_DW'(cfg_q.max_interval);
			REG_RATE_NUMERATOR: prdata = APB_DW'(cfg_q.rate_numerator);
			REG_BPM_FLOOR:      prdata = APB_DW'(cfg_q.bpm_floor);
			REG_BPM_CEILING:    prdata = APB_DW'(cfg_q.bpm_ceiling);
			REG_WINDOW_SAMPLES: prdata = APB_DW'(cfg_q.window_samples);
			default:            prdata = '0;
		endcase
	end

endmodule

// File: src/pbr_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Dividend is left-aligned; the caller sets the number of steps.
// Depends on pbr_pkg for div_req_t and div_rsp_t.
module pbr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pbr_pkg::div_req_t req,
	output pbr_pkg::div_rsp_t rsp
);
	import pbr_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [NUM_W-1:0]  dvd_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DIVS_W:0]   trial;
	logic [DIVS_W:0]   diff;
	logic              fits;

	assign trial = {rem_q, dvd_q[NUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			dvd_q <= req.dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
			dvd_q <= {dvd_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

endmodule

// File: verif/tb_pulse_beat_rate_detector.sv
`timescale 1ns / 100ps
// Self-checking testbench for pulse_beat_rate_detector: a directed table, then
// random pulse trains, across several register settings and idle patterns.
// Depends on pbr_pkg, pbr_in_if and pbr_out_if from the RTL.
module tb_pulse_beat_rate_detector;
	import pbr_pkg::*;

	localparam int RING_DEPTH   = HISTORY_DEPTH_DEF;
	localparam int SETTLE_CYCLES = 64;
	localparam int PLAN_N       = 9;
	localparam int PHASE_WORDS  = 210;
	localparam int DIR_N        = 21;

	typedef struct packed {
		logic [BPM_W-1:0]    bpm;
		logic                beat;
		logic                updated;
		logic [SAMPLE_W-1:0] thr;
	} report_word_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [TICK_W-1:0]   tick;
		logic                typed;
		logic [BPM_W-1:0]    bpm;
		logic                beat;
		logic                updated;
		logic [SAMPLE_W-1:0] thr;
	} dir_row_t;

	// typed rows are the opening beats at reset settings: max 1023, min 0
	localparam dir_row_t DIRECTED [DIR_N] = '{
		'{10'd0,    16'd0,     1'b1, 8'd0,   1'b0, 1'b0, 10'd256},
		'{10'd1023, 16'd30,    1'b1, 8'd0,   1'b1, 1'b0, 10'd511},
		'{10'd0,    16'd40,    1'b1, 8'd0,   1'b0, 1'b0, 10'd511},
		'{10'd1023, 16'd60,    1'b1, 8'd0,   1'b1, 1'b0, 10'd511},
		'{10'd0,    16'd61,    1'b1, 8'd0,   1'b0, 1'b0, 10'd511},
		'{10'd1023, 16'd90,    1'b1, 8'd180, 1'b1, 1'b1, 10'd511},
		'{10'd0,    16'd95,    1'b0, 8'd0,   1'b0, 1'b0, 10'd0},
		'{10'd1023, 16'd100,   1'b0, 8'd0,   1'b0, 1'b0, 10'd0},
		'{10'd0,    16'd150,   1'b0, 8'd0,   1'b0, 1'b0, 10'd0},
		'{10'd1023, 16'd300,   1'b0, 8'd0,   1'b0, 1'b0, 10'd0},
		'{10'd511,  16'd301,   1'b0, 8'd0,   1'b0, 1'b0, 10'd0},
		'{10'd512,  16'd290,   1'b0, 8'd0,   1'b0, 1'b0, 10'd0},
		'{10'd0,    16'd291,   1'b0, 8'd0,   1'b0, 1'b0, 10'd0},
		'{10'd1023, 16'd289,   1'b0, 8'd0,   1'b0, 1'b0, 10'd0},
		'{10'd0,    16'd300,   1'b0, 8'd0,   1'b0, 1'b0, 10'd0},
		'{10'd1023, 16'd309,   1'b0, 8'd0,   1'b0, 1'b0, 10'd0},
		'{10'd0,    16'd309,   1'b0, 8'd0,   1'b0, 1'b0, 10'd0},
		'{10'd1023, 16'd310,   1'b0, 8'd0,   1'b0, 1'b0, 10'd0},
		'{10'd0,    16'd65535, 1'b0, 8'd0,   1'b0, 1'b0, 10'd0},
		'{10'd1023, 16'd65535, 1'b0, 8'd0,   1'b0, 1'b0, 10'd0},
		'{10'd0,    16'd0,     1'b0, 8'd0,   1'b0, 1'b0, 10'd0}
	};

	// min, max, numerator, floor, ceiling, window
	localparam cfg_t CFG_PLAN [PLAN_N] = '{
		'{8'd20,  8'd200, 24'd1171875,  8'd50,  8'd180, 8'd100},
		'{8'd10,  8'd120, 24'd600000,   8'd40,  8'd200, 8'd30},
		'{8'd0,   8'd255, 24'd16777215, 8'd0,   8'd255, 8'd1},
		'{8'd30,  8'd150, 24'd3000,     8'd10,  8'd250, 8'd50},
		'{8'd5,   8'd100, 24'd100000,   8'd200, 8'd60,  8'd255},
		'{8'd0,   8'd64,  24'd1,        8'd0,   8'd255, 8'd0},
		'{8'd255, 8'd255, 24'd5000,     8'd0,   8'd255, 8'd8},
		'{8'd1,   8'd254, 24'd8000,     8'd0,   8'd255, 8'd200},
		'{8'd20,  8'd200, 24'd1171875,  8'd50,  8'd180, 8'd100}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	pbr_in_if  pulse_bus ();
	pbr_out_if report_bus ();

	pulse_beat_rate_detector u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pulse   (pulse_bus),
		.report  (report_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #6 clk = ~clk;

	// shadow of the detector
	cfg_t                cfg_shadow;
	logic [SAMPLE_W-1:0] trk_max;
	logic [SAMPLE_W-1:0] trk_min;
	logic [SAMPLE_W-1:0] prev_sample;
	logic [TICK_W-1:0]   last_tick;
	logic [IVL_W-1:0]    ivl_ring [RING_DEPTH];
	int unsigned         ring_pos;
	int unsigned         beats;
	logic [8:0]          win_cnt;
	logic [BPM_W-1:0]    bpm_now;

	report_word_t expected_reports [$];
	int err_count = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;

	// pulse train generator
	int wv_pos = 0;
	int wv_half;
	int wv_step;
	int wv_lo;
	int wv_hi;
	logic [TICK_W-1:0] tick_now;

	task automatic flag_mismatch(input string what);
		$display("ERROR at %0t: %s", $time, what);
		err_count++;
	endtask

	task automatic reset_tracker();
		cfg_shadow = '{MIN_INTERVAL_RST, MAX_INTERVAL_RST, RATE_NUMERATOR_RST,
			BPM_FLOOR_RST, BPM_CEILING_RST, WINDOW_SAMPLES_RST};
		trk_max = TRACK_RST;
		trk_min = TRACK_RST;
		prev_sample = '0;
		last_tick = '0;
		ring_pos = 0;
		beats = 0;
		win_cnt = '0;
		bpm_now = '0;
	endtask

	function automatic logic [BPM_W-1:0] mean_rate();
		int unsigned total;
		int unsigned mean;
		int unsigned rate;
		total = 0;
		for (int k = 0; k < beats && k < RING_DEPTH; k++)
			total += 32'(ivl_ring[k]);
		mean = (beats != 0) ? total / beats : 0;
		if (mean == 0)
			return cfg_shadow.bpm_ceiling;
		rate = 32'(cfg_shadow.rate_numerator) / mean;
		if (rate < cfg_shadow.bpm_floor)
			rate = 32'(cfg_shadow.bpm_floor);
		if (rate > cfg_shadow.bpm_ceiling)
			rate = 32'(cfg_shadow.bpm_ceiling);
		return rate[BPM_W-1:0];
	endfunction

	function automatic report_word_t track_pulse(input logic [SAMPLE_W-1:0] s,
		input logic [TICK_W-1:0] ts);
		report_word_t r;
		logic [TICK_W-1:0] gap;
		int unsigned slot;
		r = '0;
		if (s > trk_max)
			trk_max = s;
		if (s < trk_min)
			trk_min = s;
		if (trk_max >= trk_min)
			r.thr = trk_min + SAMPLE_W'((trk_max - trk_min) >> 1);
		else
			r.thr = trk_max + SAMPLE_W'((trk_min - trk_max) >> 1);
		if (s > r.thr && prev_sample <= r.thr) begin
			gap = ts - last_tick;
			if (gap > cfg_shadow.min_interval && gap < cfg_shadow.max_interval) begin
				slot = (ring_pos >= RING_DEPTH) ? 0 : ring_pos;
				ivl_ring[slot] = gap[IVL_W-1:0];
				ring_pos = (slot + 1) % RING_DEPTH;
				if (beats < RING_DEPTH)
					beats++;
				if (beats >= MIN_BEATS) begin
					bpm_now = mean_rate();
					r.updated = 1'b1;
				end
				last_tick = ts;
				r.beat = 1'b1;
			end
		end
		prev_sample = s;
		win_cnt = win_cnt + 9'd1;
		if (win_cnt >= cfg_shadow.window_samples) begin
			win_cnt = '0;
			trk_max = s;
			trk_min = s;
		end
		r.bpm = bpm_now;
		return r;
	endfunction

	task automatic cfg_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_MIN_INTERVAL:   cfg_shadow.min_interval = value[IVL_W-1:0];
			REG_MAX_INTERVAL:   cfg_shadow.max_interval = value[IVL_W-1:0];
			REG_RATE_NUMERATOR: cfg_shadow.rate_numerator = value[NUM_W-1:0];
			REG_BPM_FLOOR:      cfg_shadow.bpm_floor = value[BPM_W-1:0];
			REG_BPM_CEILING:    cfg_shadow.bpm_ceiling = value[BPM_W-1:0];
			REG_WINDOW_SAMPLES: cfg_shadow.window_samples = value[IVL_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_plan(input cfg_t plan);
		cfg_write(REG_MIN_INTERVAL, APB_DW'(plan.min_interval));
		cfg_write(REG_MAX_INTERVAL, APB_DW'(plan.max_interval));
		cfg_write(REG_RATE_NUMERATOR, APB_DW'(plan.rate_numerator));
		cfg_write(REG_BPM_FLOOR, APB_DW'(plan.bpm_floor));
		cfg_write(REG_BPM_CEILING, APB_DW'(plan.bpm_ceiling));
		cfg_write(REG_WINDOW_SAMPLES, APB_DW'(plan.window_samples));
	endtask

	// call at a falling edge
	task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic [TICK_W-1:0] ts,
		input logic typed, input report_word_t want);
		report_word_t pred;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			pulse_bus.valid <= 1'b0;
			@(negedge clk);
		end
		pulse_bus.valid <= 1'b1;
		pulse_bus.sample <= s;
		pulse_bus.timestamp <= ts;
		@(posedge clk);
		while (!pulse_bus.ready)
			@(posedge clk);
		pred = track_pulse(s, ts);
		expected_reports.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		pulse_bus.valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_reports.size() != 0);
	endtask

	task automatic settle();
		hold_until_drained();
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	function automatic int clamp_level(input int v);
		if (v < 0)
			return 0;
		if (v > 1023)
			return 1023;
		return v;
	endfunction

	// mostly square-ish pulse trains with jitter, some noise and tick jumps
	task automatic next_pulse_word(output logic [SAMPLE_W-1:0] s, output logic [TICK_W-1:0] ts);
		int roll;
		int level;
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			tick_now = TICK_W'($urandom_range(0, 65535));
			s = SAMPLE_W'($urandom_range(0, 1023));
		end else if (roll < 10) begin
			tick_now = tick_now + TICK_W'($urandom_range(0, 300));
			s = SAMPLE_W'($urandom_range(0, 1023));
		end else begin
			if (wv_pos == 0) begin
				wv_half = $urandom_range(1, 6);
				wv_step = $urandom_range(1, 14);
				wv_lo = $urandom_range(0, 450);
				wv_hi = $urandom_range(560, 1023);
			end
			level = (wv_pos < wv_half) ? wv_lo : wv_hi;
			level = clamp_level(level + int'($urandom_range(0, 20)) - 10);
			s = level[SAMPLE_W-1:0];
			wv_pos = (wv_pos + 1) % (2 * wv_half);
			tick_now = tick_now + TICK_W'(wv_step);
		end
		ts = tick_now;
	endtask

	always @(negedge clk)
		report_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);

	always @(posedge clk) begin
		report_word_t want;
		if (arst_n && report_bus.valid && report_bus.ready) begin
			if (expected_reports.size() == 0) begin
				flag_mismatch("result word with nothing expected");
			end else begin
				want = expected_reports.pop_front();
				if (report_bus.bpm !== want.bpm)
					flag_mismatch($sformatf("bpm got %0d want %0d", report_bus.bpm, want.bpm));
				if (report_bus.beat_detected !== want.beat)
					flag_mismatch($sformatf("beat_detected got %0b want %0b",
						report_bus.beat_detected, want.beat));
				if (report_bus.bpm_updated !== want.updated)
					flag_mismatch($sformatf("bpm_updated got %0b want %0b",
						report_bus.bpm_updated, want.updated));
				if (report_bus.threshold_level !== want.thr)
					flag_mismatch($sformatf("threshold_level got %0d want %0d",
						report_bus.threshold_level, want.thr));
			end
		end
	end

	initial begin
		#15_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [SAMPLE_W-1:0] s;
		logic [TICK_W-1:0] ts;
		report_word_t want;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pulse_bus.valid = 1'b0;
		pulse_bus.sample = '0;
		pulse_bus.timestamp = '0;
		report_bus.ready = 1'b0;
		tick_now = TICK_W'($urandom_range(0, 65535));
		reset_tracker();
		repeat (8)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			want = '{DIRECTED[i].bpm, DIRECTED[i].beat, DIRECTED[i].updated, DIRECTED[i].thr};
			send_word(DIRECTED[i].sample, DIRECTED[i].tick, DIRECTED[i].typed, want);
		end
		settle();

		for (int p = 0; p < PLAN_N; p++) begin
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 79; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 79; end
				default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
			endcase
			apply_plan(CFG_PLAN[p]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if ((p == 0 && n == PHASE_WORDS / 2) || $urandom_range(0, 149) == 0)
					hold_until_drained();
				next_pulse_word(s, ts);
				send_word(s, ts, 1'b0, '0);
			end
			settle();
		end

		if (err_count == 0 && expected_reports.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: pulse_beat_rate_detector.f
src/pbr_pkg.sv
src/pbr_in_if.sv
src/pbr_out_if.sv
src/pbr_regs.sv
src/pbr_div.sv
src/pulse_beat_rate_detector.sv
verif/tb_pulse_beat_rate_detector.sv
